### hdl/frdc_pkg.sv
// ----------------------------------------------------------------------------
// frdc_pkg: shared definitions for the frame receiver
// Byte codes, result codes, and the transaction formats that pass between
// the front end, the frame engine and the queues.
// ----------------------------------------------------------------------------
package frdc_pkg;

  // Line byte codes.
  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_XOR      = 8'h20;
  localparam logic [7:0] ADDR_DEFAULT = 8'h03;

  // Field widths fixed by the interface.
  localparam int unsigned LEN_W = 12;

  // Configuration register indexes.
  localparam logic CFG_ADDRESS     = 1'b0;
  localparam logic CFG_MAX_PAYLOAD = 1'b1;

  // Result item kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Frame kinds.
  localparam logic FRAME_CMD  = 1'b0;
  localparam logic FRAME_DATA = 1'b1;

  // Error codes.
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_CHECK    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // Classified line symbol from the front end.
  typedef struct packed {
    logic       is_flag;
    logic [7:0] data;
  } tok_t;

  // One result item.
  typedef struct packed {
    logic             item_kind;
    logic [7:0]       payload_byte;
    logic             frame_kind;
    logic [1:0]       error_code;
    logic [7:0]       control_value;
    logic             sequence_bit;
    logic [LEN_W-1:0] payload_length;
  } res_t;

  localparam int unsigned TOK_W = $bits(tok_t);
  localparam int unsigned RES_W = $bits(res_t);

endpackage

### hdl/frdc_fifo.sv
// ----------------------------------------------------------------------------
// frdc_fifo: small register queue
// First-in first-out buffer built from flops. The head entry is visible on
// rd_data while empty is low; full and empty come straight from the count.
// ----------------------------------------------------------------------------
module frdc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; entries are read only after being written.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hdl/frdc_front.sv
// ----------------------------------------------------------------------------
// frdc_front: line byte classifier and destuffer
// Accepts raw line bytes, removes escape sequences and tags flags. Each
// byte other than an unescaped escape marker becomes one symbol for the
// frame engine.
// ----------------------------------------------------------------------------
module frdc_front
  import frdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_rx_byte,
  output logic       in_full,
  output logic       tok_push,
  output tok_t       tok_data,
  input  logic       tok_full
);

  logic escape_r, escape_nxt;
  logic accept;
  logic is_flag, is_esc;

  assign in_full = tok_full;
  assign accept  = in_push && !tok_full;
  assign is_flag = (in_rx_byte == FLAG_BYTE);
  assign is_esc  = (in_rx_byte == ESC_BYTE);

  // A flag always wins and drops a pending escape; an escape marker after
  // an escape is taken as escaped data.
  always_comb begin
    escape_nxt       = escape_r;
    tok_push         = 1'b0;
    tok_data.is_flag = is_flag;
    tok_data.data    = escape_r ? (in_rx_byte ^ ESC_XOR) : in_rx_byte;
    if (accept) begin
      if (is_flag) begin
        escape_nxt = 1'b0;
        tok_push   = 1'b1;
      end else if (is_esc && !escape_r) begin
        escape_nxt = 1'b1;
      end else begin
        escape_nxt = 1'b0;
        tok_push   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= 1'b0;
    end else begin
      escape_r <= escape_nxt;
    end
  end

endmodule

### hdl/frdc_back.sv
// ----------------------------------------------------------------------------
// frdc_back: frame engine
// Consumes classified symbols, tracks the frame header, delays payload by
// one byte, accumulates the payload check and issues payload and status
// results.
// ----------------------------------------------------------------------------
module frdc_back
  import frdc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       address_byte,
  input  logic [LEN_W-1:0] max_payload,
  input  tok_t             tok_data,
  input  logic             tok_empty,
  output logic             tok_pop,
  output logic             res_push,
  output res_t             res_data,
  input  logic             res_full
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_ADDR,
    ST_CTRL,
    ST_CHECK,
    ST_BODY
  } state_t;

  state_t                 state_r, state_nxt;
  logic [7:0]             control_r, control_nxt;
  logic [7:0]             held_r, held_nxt;
  logic                   held_valid_r, held_valid_nxt;
  logic [7:0]             xor_r, xor_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  logic             go;
  logic             over;
  logic [7:0]       d;
  logic [LEN_W-1:0] count_len;

  assign go      = !tok_empty && !res_full;
  assign tok_pop = go;
  assign d       = tok_data.data;

  // Length limit check, done at a width that holds both operands.
  assign over = (CMP_W'(count_r) >= CMP_W'(max_payload)) || (count_r == COUNT_MAX);

  generate
    if (COUNT_WIDTH >= LEN_W) begin : g_len_trunc
      assign count_len = count_r[LEN_W-1:0];
    end else begin : g_len_ext
      assign count_len = LEN_W'(count_r);
    end
  endgenerate

  // Per-symbol frame tracking.
  always_comb begin
    state_nxt      = state_r;
    control_nxt    = control_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    xor_nxt        = xor_r;
    count_nxt      = count_r;
    res_push       = 1'b0;
    res_data       = '0;
    if (go) begin
      if (state_r == ST_HUNT) begin
        if (tok_data.is_flag) begin
          state_nxt = ST_ADDR;
        end
      end else if (tok_data.is_flag) begin
        if (state_r == ST_BODY) begin
          // Closing flag: report the frame.
          state_nxt              = ST_HUNT;
          held_valid_nxt         = 1'b0;
          res_push               = 1'b1;
          res_data.item_kind     = KIND_STATUS;
          res_data.control_value = control_r;
          if (!held_valid_r) begin
            res_data.frame_kind   = FRAME_CMD;
            res_data.error_code   = ERR_OK;
            res_data.sequence_bit = control_r[7];
          end else begin
            res_data.frame_kind     = FRAME_DATA;
            res_data.error_code     = (held_r == xor_r) ? ERR_OK : ERR_CHECK;
            res_data.sequence_bit   = control_r[6];
            res_data.payload_length = count_len;
          end
        end else begin
          state_nxt = ST_ADDR;
        end
      end else begin
        unique case (state_r)
          ST_ADDR: begin
            state_nxt = (d == address_byte) ? ST_CTRL : ST_HUNT;
          end
          ST_CTRL: begin
            control_nxt = d;
            state_nxt   = ST_CHECK;
          end
          ST_CHECK: begin
            if (d == (address_byte ^ control_r)) begin
              state_nxt      = ST_BODY;
              held_valid_nxt = 1'b0;
              held_nxt       = '0;
              xor_nxt        = '0;
              count_nxt      = '0;
            end else begin
              state_nxt = ST_HUNT;
            end
          end
          ST_BODY: begin
            if (held_valid_r) begin
              res_push = 1'b1;
              if (over) begin
                // Payload too long: report and drop the rest of the frame.
                state_nxt               = ST_HUNT;
                held_valid_nxt          = 1'b0;
                res_data.item_kind      = KIND_STATUS;
                res_data.frame_kind     = FRAME_DATA;
                res_data.error_code     = ERR_OVERFLOW;
                res_data.control_value  = control_r;
                res_data.sequence_bit   = control_r[6];
                res_data.payload_length = count_len;
              end else begin
                res_data.item_kind    = KIND_PAYLOAD;
                res_data.payload_byte = held_r;
                xor_nxt               = xor_r ^ held_r;
                count_nxt             = count_r + 1'b1;
                held_nxt              = d;
              end
            end else begin
              held_nxt       = d;
              held_valid_nxt = 1'b1;
            end
          end
          default: begin
            state_nxt = ST_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_HUNT;
      control_r    <= '0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      xor_r        <= '0;
      count_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      control_r    <= control_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      xor_r        <= xor_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

### hdl/frame_receive_destuff_check.sv
// ----------------------------------------------------------------------------
// frame_receive_destuff_check: byte-stuffed framed receiver
// Top level: configuration registers, front end, symbol queue, frame
// engine and result queue.
// ----------------------------------------------------------------------------
// The receiver takes one raw line byte per cycle (push while full is low)
// and keeps that rate indefinitely as long as results are popped at the
// same pace. A byte passes the destuffing front end into a two-entry
// symbol queue, the frame engine handles one symbol per cycle and writes
// any result into a two-entry result queue; the symbol queue and then the
// result queue are registered between an accepted byte and its result. When
// the result queue fills, the frame engine stalls, the symbol queue fills
// behind it and full rises. Payload bytes come out one byte late; the
// final byte before the closing flag is the payload check and is reported
// in the end-of-frame status instead. Configuration writes are always
// taken (cfg_ready is tied high) and must only be issued while the block
// is idle.
// ----------------------------------------------------------------------------
module frame_receive_destuff_check
  import frdc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  // Raw line bytes
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  // Results
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_item_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_frame_kind,
  output logic [1:0]  out_error_code,
  output logic [7:0]  out_control_value,
  output logic        out_sequence_bit,
  output logic [11:0] out_payload_length
);

  logic [7:0]       address_r;
  logic [LEN_W-1:0] max_payload_r;

  logic             tok_push, tok_full, tok_pop, tok_empty;
  tok_t             tok_wr, tok_rd;
  logic [TOK_W-1:0] tok_rd_bits;
  logic             res_push, res_full;
  res_t             res_wr, res_rd;
  logic [RES_W-1:0] res_rd_bits;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r     <= ADDR_DEFAULT;
      max_payload_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ADDRESS:     address_r     <= cfg_data[7:0];
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Front end: destuffing and flag detection.
  frdc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .tok_push   (tok_push),
    .tok_data   (tok_wr),
    .tok_full   (tok_full)
  );

  // Symbol queue between front end and frame engine.
  frdc_fifo #(
    .WIDTH (TOK_W),
    .DEPTH (2)
  ) u_tok_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (tok_push),
    .wr_data (tok_wr),
    .full    (tok_full),
    .pop     (tok_pop),
    .rd_data (tok_rd_bits),
    .empty   (tok_empty)
  );

  assign tok_rd = tok_t'(tok_rd_bits);

  // Frame engine.
  frdc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .address_byte (address_r),
    .max_payload  (max_payload_r),
    .tok_data     (tok_rd),
    .tok_empty    (tok_empty),
    .tok_pop      (tok_pop),
    .res_push     (res_push),
    .res_data     (res_wr),
    .res_full     (res_full)
  );

  // Result queue.
  frdc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rd_bits),
    .empty   (out_empty)
  );

  assign res_rd = res_t'(res_rd_bits);

  assign out_item_kind      = res_rd.item_kind;
  assign out_payload_byte   = res_rd.payload_byte;
  assign out_frame_kind     = res_rd.frame_kind;
  assign out_error_code     = res_rd.error_code;
  assign out_control_value  = res_rd.control_value;
  assign out_sequence_bit   = res_rd.sequence_bit;
  assign out_payload_length = res_rd.payload_length;

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for frame_receive_destuff_check
// Feeds stuffed line bytes through the input queue port and tracks the
// receiver state alongside the block, so that every payload byte and every
// end-of-frame status is known before it is popped. A short directed
// stream opens the run. Random frames follow under several address and
// length settings, mixed with noise and broken headers, and the run ends
// with a long stall on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import frdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES   = 250;
  localparam logic [11:0] COUNT_TOP     = 12'hFFF;

  typedef enum logic [2:0] {
    SEEK_FLAG,
    GET_ADDR,
    GET_CTRL,
    GET_HCS,
    IN_BODY
  } rx_phase_t;

  // Tracks the receiver state and holds the results still to be popped.
  class rx_result_tracker_t;
    logic [7:0]  addr_reg     = ADDR_DEFAULT;
    logic [11:0] max_len_reg  = 12'd4095;
    rx_phase_t   phase        = SEEK_FLAG;
    logic        esc_seen     = 1'b0;
    logic [7:0]  ctrl_hold    = 8'h00;
    logic [7:0]  held         = 8'h00;
    logic        held_ok      = 1'b0;
    logic [7:0]  xor_acc      = 8'h00;
    logic [11:0] count        = '0;
    res_t        pending_results[$];
    int unsigned useful_bytes = 0;
    int unsigned mismatches   = 0;
    int unsigned checked      = 0;

    function void set_reg(logic idx, logic [11:0] val);
      if (idx == CFG_ADDRESS) begin
        addr_reg = val[7:0];
      end else begin
        max_len_reg = val;
      end
    endfunction

    function void push_status(logic fkind, logic [1:0] err, logic [11:0] len);
      res_t r;
      r = '0;
      r.item_kind      = KIND_STATUS;
      r.frame_kind     = fkind;
      r.error_code     = err;
      r.control_value  = ctrl_hold;
      r.sequence_bit   = (fkind == FRAME_DATA) ? ctrl_hold[6] : ctrl_hold[7];
      r.payload_length = len;
      pending_results.push_back(r);
    endfunction

    // Advance the receiver by one accepted line byte.
    function void absorb_byte(logic [7:0] raw);
      logic [7:0] d;
      res_t       r;
      if (phase != SEEK_FLAG || raw == FLAG_BYTE) useful_bytes++;

      // While hunting only an opening flag matters.
      if (phase == SEEK_FLAG) begin
        esc_seen = 1'b0;
        if (raw == FLAG_BYTE) phase = GET_ADDR;
        return;
      end

      // A flag always wins, even right after an escape.
      if (raw == FLAG_BYTE) begin
        esc_seen = 1'b0;
        if (phase == IN_BODY) begin
          phase = SEEK_FLAG;
          if (!held_ok) begin
            push_status(FRAME_CMD, ERR_OK, '0);
          end else begin
            push_status(FRAME_DATA, (held == xor_acc) ? ERR_OK : ERR_CHECK, count);
          end
          held_ok = 1'b0;
        end else begin
          phase = GET_ADDR;
        end
        return;
      end

      // Destuffing: an escape marks the next byte, a second escape is data.
      if (raw == ESC_BYTE && !esc_seen) begin
        esc_seen = 1'b1;
        return;
      end
      d = esc_seen ? (raw ^ ESC_XOR) : raw;
      esc_seen = 1'b0;

      case (phase)
        GET_ADDR: phase = (d == addr_reg) ? GET_CTRL : SEEK_FLAG;
        GET_CTRL: begin
          ctrl_hold = d;
          phase = GET_HCS;
        end
        GET_HCS: begin
          if (d == (addr_reg ^ ctrl_hold)) begin
            phase   = IN_BODY;
            held_ok = 1'b0;
            held    = 8'h00;
            xor_acc = 8'h00;
            count   = '0;
          end else begin
            phase = SEEK_FLAG;
          end
        end
        IN_BODY: begin
          // Body bytes leave one byte late; the last one is the check.
          if (!held_ok) begin
            held    = d;
            held_ok = 1'b1;
          end else if (count >= max_len_reg || count == COUNT_TOP) begin
            push_status(FRAME_DATA, ERR_OVERFLOW, count);
            phase   = SEEK_FLAG;
            held_ok = 1'b0;
          end else begin
            r = '0;
            r.item_kind    = KIND_PAYLOAD;
            r.payload_byte = held;
            pending_results.push_back(r);
            xor_acc = xor_acc ^ held;
            count   = count + 12'd1;
            held    = d;
          end
        end
        default: phase = SEEK_FLAG;
      endcase
    endfunction

    task report(string msg);
      if (mismatches < 50) $display("MISMATCH %s", msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [11:0] got, logic [11:0] want);
      if (got !== want) begin
        report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h", checked, name, got, want));
      end
    endtask

    // Compare one popped result with the oldest expectation.
    task check_item(res_t got);
      res_t want;
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
        return;
      end
      want = pending_results.pop_front();
      compare_field("item_kind", 12'(got.item_kind), 12'(want.item_kind));
      compare_field("payload_byte", 12'(got.payload_byte), 12'(want.payload_byte));
      compare_field("frame_kind", 12'(got.frame_kind), 12'(want.frame_kind));
      compare_field("error_code", 12'(got.error_code), 12'(want.error_code));
      compare_field("control_value", 12'(got.control_value), 12'(want.control_value));
      compare_field("sequence_bit", 12'(got.sequence_bit), 12'(want.sequence_bit));
      compare_field("payload_length", got.payload_length, want.payload_length);
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = CFG_ADDRESS;
  logic [11:0] cfg_data   = '0;
  logic        in_push    = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_empty;
  logic        out_pop    = 1'b0;
  logic        out_item_kind;
  logic [7:0]  out_payload_byte;
  logic        out_frame_kind;
  logic [1:0]  out_error_code;
  logic [7:0]  out_control_value;
  logic        out_sequence_bit;
  logic [11:0] out_payload_length;

  bit          send_idle   = 1'b1;
  bit          pop_idle    = 1'b1;
  bit          hold_req    = 1'b0;
  int unsigned cycle_count = 0;

  rx_result_tracker_t sb = new;

  frame_receive_destuff_check dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_rx_byte         (in_rx_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_item_kind      (out_item_kind),
    .out_payload_byte   (out_payload_byte),
    .out_frame_kind     (out_frame_kind),
    .out_error_code     (out_error_code),
    .out_control_value  (out_control_value),
    .out_sequence_bit   (out_sequence_bit),
    .out_payload_length (out_payload_length)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One line byte transaction, after a random number of idle cycles while send_idle is set.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    sb.absorb_byte(b);
  endtask

  // Stuff a frame byte; ordinary bytes are sometimes escaped too.
  task automatic send_data(input logic [7:0] d);
    if (d == FLAG_BYTE || d == ESC_BYTE || $urandom_range(0, 15) == 0) begin
      send_byte(ESC_BYTE);
      send_byte(d ^ ESC_XOR);
    end else begin
      send_byte(d);
    end
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] ctrl,
                            input int unsigned len, input bit is_cmd,
                            input logic [7:0] hcs_flip, input logic [7:0] check_flip);
    logic [7:0] sum;
    logic [7:0] d;
    sum = 8'h00;
    send_byte(FLAG_BYTE);
    send_data(addr);
    send_data(ctrl);
    send_data(addr ^ ctrl ^ hcs_flip);
    if (!is_cmd) begin
      repeat (len) begin
        d = 8'($urandom_range(0, 255));
        sum = sum ^ d;
        send_data(d);
      end
      send_data(sum ^ check_flip);
    end
    send_byte(FLAG_BYTE);
  endtask

  // Mostly well-formed frames, with bad checks, bad headers and noise.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned cap;
    logic [7:0]  a;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    cap  = (sb.max_len_reg < 22) ? sb.max_len_reg + 2 : 24;
    a    = sb.addr_reg;
    c    = 8'($urandom_range(0, 255));
    send_idle = ($urandom_range(0, 3) != 0);
    if (pick < 60) begin
      send_frame(a, c, $urandom_range(0, cap), 1'b0, 8'h00, 8'h00);
    end else if (pick < 70) begin
      send_frame(a, c, 0, 1'b1, 8'h00, 8'h00);
    end else if (pick < 78) begin
      send_frame(a, c, $urandom_range(0, cap), 1'b0, 8'h00, 8'($urandom_range(1, 255)));
    end else if (pick < 84) begin
      send_frame(a, c, $urandom_range(0, cap), 1'b0, 8'($urandom_range(1, 255)), 8'h00);
    end else if (pick < 89) begin
      send_frame(a ^ 8'($urandom_range(1, 255)), c, $urandom_range(0, cap), 1'b0,
                 8'h00, 8'h00);
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      // Header cut short by a flag, sometimes right after an escape.
      send_byte(FLAG_BYTE);
      send_data(a);
      if ($urandom_range(0, 1)) send_data(c);
      if ($urandom_range(0, 1)) send_byte(ESC_BYTE);
      send_byte(FLAG_BYTE);
    end
  endtask

  // Register write transaction.
  task automatic write_reg(input logic idx, input logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and wait until every expected result has been popped,
  // then let bytes that cause no result drain from the pipeline.
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: pop with random gaps, honor a long hold when asked.
  initial begin : result_side
    int unsigned gap;
    res_t        got;
    wait (rst_n === 1'b1);
    forever begin
      gap = !pop_idle ? 0 : $urandom_range(0, 8);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = LONG_HOLD;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      got.item_kind      = out_item_kind;
      got.payload_byte   = out_payload_byte;
      got.frame_kind     = out_frame_kind;
      got.error_code     = out_error_code;
      got.control_value  = out_control_value;
      got.sequence_bit   = out_sequence_bit;
      got.payload_length = out_payload_length;
      sb.check_item(got);
      if ($urandom_range(0, 31) == 0) pop_idle = !pop_idle;
    end
  end

  // Line side: directed bytes, random phases, then a stall.
  initial begin : line_side
    logic [7:0]  early_bytes [] = '{
      // Garbage while hunting, repeated flags, then a wrong address.
      8'h00, 8'hFF, 8'h7E, 8'h7E, 8'h7E, 8'h04,
      // Flag in place of control, flag in place of the header check,
      // then a command frame with control 0xFF.
      8'h7E, 8'h03, 8'h7E, 8'h03, 8'h00, 8'h7E, 8'h03, 8'hFF, 8'hFC, 8'h7E,
      // The closing flag does not open a frame; empty payload, check 0.
      8'h03, 8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'h7E,
      // Escaped flag, escape after escape, good check.
      8'h7E, 8'h03, 8'h40, 8'h43, 8'h7D, 8'h5E, 8'h7D, 8'h7D, 8'h23, 8'h7E,
      // Flag after an escape ends the frame with a check mismatch.
      8'h7E, 8'h03, 8'h41, 8'h42, 8'h11, 8'h7D, 8'h7E
    };
    logic [7:0]  short_limit_bytes [] = '{
      // With a one-byte limit: overflow, then a frame exactly at the limit.
      8'h7E, 8'h03, 8'h01, 8'h02, 8'hAA, 8'hBB, 8'hCC, 8'h7E,
      8'h7E, 8'h03, 8'h01, 8'h02, 8'hAA, 8'hAA, 8'h7E
    };
    logic [7:0]  a;
    logic [11:0] m;
    int unsigned target;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (early_bytes[i]) send_byte(early_bytes[i]);
    settle();
    write_reg(CFG_MAX_PAYLOAD, 12'd1);
    foreach (short_limit_bytes[i]) send_byte(short_limit_bytes[i]);

    // Random phases, each under its own address and length limit.
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin a = 8'h00; m = 12'd1; end
        1: begin a = 8'hFF; m = 12'd4095; end
        2: begin a = FLAG_BYTE; m = 12'($urandom_range(2, 20)); end
        3: begin a = ESC_BYTE; m = 12'd2; end
        default: begin
          a = 8'($urandom_range(0, 255));
          m = 12'($urandom_range(1, 30));
        end
      endcase
      write_reg(CFG_ADDRESS, {4'h0, a});
      write_reg(CFG_MAX_PAYLOAD, m);
      target = sb.useful_bytes + PHASE_BYTES;
      while (sb.useful_bytes < target) send_random_frame();
    end

    // Result side holds off while bytes keep coming, so full must rise.
    settle();
    write_reg(CFG_MAX_PAYLOAD, 12'd4095);
    send_idle = 1'b0;
    hold_req  = 1'b1;
    send_frame(sb.addr_reg, 8'($urandom_range(0, 255)), 80, 1'b0, 8'h00, 8'h00);
    settle();

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/frdc_pkg.sv
hdl/frdc_fifo.sv
hdl/frdc_front.sv
hdl/frdc_back.sv
hdl/frame_receive_destuff_check.sv
test/testbench.sv
